/* hw/rtl/lgs_pkg.sv */
// ----------------------------------------------------------------------------
// lgs_pkg: shared definitions for the Life generation step core
//
// Board geometry, register map and the row update function that turns three
// neighboring board rows into one row of the next generation.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

   localparam int MAX_SIDE = 64;
   localparam int ROW_W    = 64;
   localparam int IDX_W    = $clog2(MAX_SIDE);
   localparam int SIDE_W   = IDX_W + 1;
   localparam int COUNT_W  = 4;

   localparam logic [SIDE_W-1:0] BOARD_SIZE_RESET = SIDE_W'(MAX_SIDE);

   // Life rule thresholds.
   localparam logic [COUNT_W-1:0] KEEP_COUNT  = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] BIRTH_COUNT = COUNT_W'(3);

   // Register map: 32-bit registers at word addresses; board_size is the only one.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_LSB = 2;
   localparam logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] REG_BOARD_SIZE = '0;

   // Board side actually used: zero counts as one, anything above the maximum
   // is clamped.
   function automatic logic [SIDE_W-1:0] side_in_use(input logic [SIDE_W-1:0] size);
      logic [SIDE_W-1:0] s;
      s = size;
      if (s == '0) begin
         s = SIDE_W'(1);
      end
      if (s > SIDE_W'(MAX_SIDE)) begin
         s = SIDE_W'(MAX_SIDE);
      end
      return s;
   endfunction

   // Bit c takes the cell at column c-1, with column 0 wrapping to side-1.
   function automatic logic [ROW_W-1:0] from_lower(input logic [ROW_W-1:0] w,
                                                   input logic [SIDE_W-1:0] side);
      logic [IDX_W-1:0] last;
      last = IDX_W'(side - SIDE_W'(1));
      return {w[ROW_W-2:0], w[last]};
   endfunction

   // Bit c takes the cell at column c+1, with column side-1 wrapping to 0.
   function automatic logic [ROW_W-1:0] from_upper(input logic [ROW_W-1:0] w,
                                                   input logic [SIDE_W-1:0] side);
      logic [IDX_W-1:0] last;
      logic [ROW_W-1:0] res;
      last = IDX_W'(side - SIDE_W'(1));
      for (int c = 0; c < ROW_W - 1; c++) begin
         res[c] = (IDX_W'(c) == last) ? w[0] : w[c+1];
      end
      res[ROW_W-1] = w[0];
      return res;
   endfunction

   // One row of the next generation from the rows above, at and below it.
   // Every column is an independent lane.
   function automatic logic [ROW_W-1:0] life_row(input logic [ROW_W-1:0] above,
                                                 input logic [ROW_W-1:0] here,
                                                 input logic [ROW_W-1:0] below,
                                                 input logic [SIDE_W-1:0] side);
      logic [ROW_W-1:0] al, ar, hl, hr, bl, br;
      logic [ROW_W-1:0] res;
      logic [COUNT_W-1:0] cnt;
      al = from_lower(above, side);
      ar = from_upper(above, side);
      hl = from_lower(here, side);
      hr = from_upper(here, side);
      bl = from_lower(below, side);
      br = from_upper(below, side);
      for (int c = 0; c < ROW_W; c++) begin
         cnt = COUNT_W'(al[c]) + COUNT_W'(above[c]) + COUNT_W'(ar[c])
             + COUNT_W'(hl[c]) + COUNT_W'(hr[c])
             + COUNT_W'(bl[c]) + COUNT_W'(below[c]) + COUNT_W'(br[c]);
         res[c] = ((cnt == BIRTH_COUNT) || ((cnt == KEEP_COUNT) && here[c]))
                  && (SIDE_W'(c) < side);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/life_generation_step_core.sv */
// ----------------------------------------------------------------------------
// life_generation_step_core: one generation of Life on a toroidal board
//
// Loads a square board row by row, then emits the next generation row by row.
// ----------------------------------------------------------------------------
// Each accepted word is one board row. The word that completes the board (the
// count of loaded rows reaching board_size) starts the update: the block stops
// accepting rows and emits board_size result words, row 0 first, with
// last_row set on the final one. Rows are read back from a single-read-port
// row RAM and go one at a time through a shared 64-column row update unit, so
// each result word goes through a read, an update and a present step. Before
// the first one, two extra read and capture steps fill the three-row window.
// Stalls on the result side hold the block in the present step. Row loading
// resumes in the cycle after the last result word is taken. board_size of 0
// acts as 1, values above 64 act as 64; bits at and above the side are ignored
// on input and zero on output.
`default_nettype none

module life_generation_step_core (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // Row input
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic [lgs_pkg::ROW_W-1:0]                req_row_bits,
   // Result output
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic      [lgs_pkg::ROW_W-1:0]                rsp_next_row_bits,
   output logic      [lgs_pkg::IDX_W-1:0]                rsp_row_number,
   output logic                                          rsp_last_row,
   // Register port
   input  wire logic                                     csr_psel,
   input  wire logic                                     csr_penable,
   input  wire logic                                     csr_pwrite,
   input  wire logic [lgs_pkg::CSR_ADDR_W-1:0]           csr_paddr,
   input  wire logic [lgs_pkg::CSR_DATA_W-1:0]           csr_pwdata,
   output logic      [lgs_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                          csr_pready
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FETCH,
      ST_CAPTURE,
      ST_EMIT
   } state_type;

   state_type                       state_ff, state_in;
   logic [lgs_pkg::SIDE_W-1:0]      board_size_ff, board_size_in;
   logic [lgs_pkg::SIDE_W-1:0]      rows_loaded_ff, rows_loaded_in;
   logic [lgs_pkg::IDX_W-1:0]       rd_addr_ff, rd_addr_in;
   logic [1:0]                      fill_cnt_ff, fill_cnt_in;
   logic [lgs_pkg::IDX_W-1:0]       out_row_ff, out_row_in;
   logic [lgs_pkg::ROW_W-1:0]       prev_ff, prev_in;
   logic [lgs_pkg::ROW_W-1:0]       cur_ff, cur_in;
   logic [lgs_pkg::ROW_W-1:0]       rsp_row_ff, rsp_row_in;

   logic [lgs_pkg::SIDE_W-1:0]      side;
   logic [lgs_pkg::IDX_W-1:0]       last_idx;
   logic [lgs_pkg::SIDE_W-1:0]      rows_next;
   logic                            req_accept;
   logic                            csr_write;
   logic                            csr_hit;
   logic                            ram_rd_en;
   logic [lgs_pkg::ROW_W-1:0]       ram_rd_data;
   logic [lgs_pkg::ROW_W-1:0]       update_row;

   assign side      = lgs_pkg::side_in_use(board_size_ff);
   assign last_idx  = lgs_pkg::IDX_W'(side - lgs_pkg::SIDE_W'(1));
   assign rows_next = rows_loaded_ff + lgs_pkg::SIDE_W'(1);

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[lgs_pkg::CSR_ADDR_W-1:lgs_pkg::CSR_IDX_LSB]
                        == lgs_pkg::REG_BOARD_SIZE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? lgs_pkg::CSR_DATA_W'(board_size_ff) : '0;

   assign ram_rd_en = (state_ff == ST_FETCH);

   lgs_ram #(
      .WIDTH (lgs_pkg::ROW_W),
      .DEPTH (lgs_pkg::MAX_SIDE)
   ) u_board_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (rows_loaded_ff[lgs_pkg::IDX_W-1:0]),
      .wr_data (req_row_bits),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   // Shared row update unit: window rows above and at the target row, with
   // the row below arriving straight from the RAM.
   assign update_row = lgs_pkg::life_row(prev_ff, cur_ff, ram_rd_data, side);

   always_comb begin
      state_in       = state_ff;
      board_size_in  = board_size_ff;
      rows_loaded_in = rows_loaded_ff;
      rd_addr_in     = rd_addr_ff;
      fill_cnt_in    = fill_cnt_ff;
      out_row_in     = out_row_ff;
      prev_in        = prev_ff;
      cur_in         = cur_ff;
      rsp_row_in     = rsp_row_ff;

      if (csr_write && csr_hit) begin
         board_size_in = csr_pwdata[lgs_pkg::SIDE_W-1:0];
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (rows_next >= side) begin
                  // Board complete: start reading at the row above row 0.
                  rows_loaded_in = '0;
                  rd_addr_in     = last_idx;
                  fill_cnt_in    = '0;
                  out_row_in     = '0;
                  state_in       = ST_FETCH;
               end else begin
                  rows_loaded_in = rows_next;
               end
            end
         end
         ST_FETCH: begin
            rd_addr_in = (rd_addr_ff == last_idx) ? '0 : rd_addr_ff + lgs_pkg::IDX_W'(1);
            state_in   = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            prev_in = cur_ff;
            cur_in  = ram_rd_data;
            if (fill_cnt_ff == 2'd2) begin
               rsp_row_in = update_row;
               state_in   = ST_EMIT;
            end else begin
               fill_cnt_in = fill_cnt_ff + 2'd1;
               state_in    = ST_FETCH;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (out_row_ff == last_idx) begin
                  state_in = ST_LOAD;
               end else begin
                  out_row_in = out_row_ff + lgs_pkg::IDX_W'(1);
                  state_in   = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         board_size_ff  <= lgs_pkg::BOARD_SIZE_RESET;
         rows_loaded_ff <= '0;
         rd_addr_ff     <= '0;
         fill_cnt_ff    <= '0;
         out_row_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         board_size_ff  <= board_size_in;
         rows_loaded_ff <= rows_loaded_in;
         rd_addr_ff     <= rd_addr_in;
         fill_cnt_ff    <= fill_cnt_in;
         out_row_ff     <= out_row_in;
      end
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      rsp_row_ff <= rsp_row_in;
   end

   assign rsp_valid         = (state_ff == ST_EMIT);
   assign rsp_next_row_bits = rsp_row_ff;
   assign rsp_row_number    = out_row_ff;
   assign rsp_last_row      = (out_row_ff == last_idx);

endmodule

`default_nettype wire

/* hw/rtl/lgs_ram.sv */
// ----------------------------------------------------------------------------
// lgs_ram: generic single-port-write, single-port-read RAM
//
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* tb/life_generation_step_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_generation_step_core_test: self-checking bench for the Life core
//
// Loads square toroidal boards row by row through the valid/stall row port
// and checks every emitted row of the next generation against a cell-level
// model kept in the bench. The board side is changed over the register port
// between phases, including while a board is half loaded. Both handshakes see
// random gaps, and the result side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module life_generation_step_core_test;

   localparam int TOTAL_ROWS       = 430;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT      = 300000;
   localparam int REPORT_LIMIT     = 10;

   typedef struct {
      logic [lgs_pkg::ROW_W-1:0] bits;
      logic [lgs_pkg::IDX_W-1:0] row;
      logic                      last;
   } life_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [lgs_pkg::ROW_W-1:0]      req_row_bits = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [lgs_pkg::ROW_W-1:0]      rsp_next_row_bits;
   logic [lgs_pkg::IDX_W-1:0]      rsp_row_number;
   logic                           rsp_last_row;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [lgs_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [lgs_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [lgs_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Bench copy of the block state.
   logic [lgs_pkg::ROW_W-1:0]  board_copy [lgs_pkg::MAX_SIDE];
   int                         rows_in_board = 0;
   logic [lgs_pkg::SIDE_W-1:0] side_setting = lgs_pkg::BOARD_SIZE_RESET;
   life_row_type               next_gen_rows [$];

   logic [lgs_pkg::ROW_W-1:0]  row_queue [$];
   int                         rows_queued = 0;
   int                         rows_accepted = 0;
   logic                       row_taken = 1'b0;
   int                         gap_left = 0;
   int                         stall_left = 0;
   bit                         calm = 1'b0;
   bit                         hold_arm = 1'b0;
   bit                         hold_active = 1'b0;

   int                         mismatch_count = 0;
   int                         words_checked = 0;
   int                         generations = 0;
   int                         side_writes = 0;
   int                         cycle_count = 0;

   life_generation_step_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_row_bits      (req_row_bits),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_row_bits (rsp_next_row_bits),
      .rsp_row_number    (rsp_row_number),
      .rsp_last_row      (rsp_last_row),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d rows still expected.",
                  cycle_count, next_gen_rows.size());
         $display("life_generation_step_core_test failed");
         $finish;
      end
   end

   function automatic int effective_side();
      if (side_setting == '0) begin
         return 1;
      end
      if (side_setting > lgs_pkg::SIDE_W'(lgs_pkg::MAX_SIDE)) begin
         return lgs_pkg::MAX_SIDE;
      end
      return int'(side_setting);
   endfunction

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) begin
         return 0;
      end
      if (r < 94) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [lgs_pkg::ROW_W-1:0] random_row();
      logic [lgs_pkg::ROW_W-1:0] a;
      logic [lgs_pkg::ROW_W-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return a;
         1: return a & b;
         2: return a | b;
         default: return a & b & {$urandom, $urandom};
      endcase
   endfunction

   // Counts the eight wrapped neighbors of every cell and queues the new rows.
   task automatic next_generation(input int n);
      logic [lgs_pkg::ROW_W-1:0] next_bits;
      life_row_type              word;
      int                        live;
      int                        rr;
      int                        cc;
      for (int r = 0; r < n; r++) begin
         next_bits = '0;
         for (int c = 0; c < n; c++) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     rr = (r + dr + n) % n;
                     cc = (c + dc + n) % n;
                     live += int'(board_copy[rr][cc]);
                  end
               end
            end
            if (live == 3 || (live == 2 && board_copy[r][c])) begin
               next_bits[c] = 1'b1;
            end
         end
         word.bits = next_bits;
         word.row  = lgs_pkg::IDX_W'(r);
         word.last = (r == n - 1);
         next_gen_rows.push_back(word);
      end
      generations++;
   endtask

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // Input acceptance feeds the model, output acceptance is checked against it.
   always @(posedge clock) begin
      life_row_type want;
      row_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            rows_accepted++;
            board_copy[rows_in_board % lgs_pkg::MAX_SIDE] = req_row_bits;
            rows_in_board++;
            if (rows_in_board >= effective_side()) begin
               rows_in_board = 0;
               next_generation(effective_side());
            end
         end
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (next_gen_rows.size() == 0) begin
               flag_mismatch($sformatf("unexpected word row %0d bits %h last %b",
                                       rsp_row_number, rsp_next_row_bits, rsp_last_row));
            end else begin
               want = next_gen_rows.pop_front();
               if (rsp_next_row_bits !== want.bits || rsp_row_number !== want.row
                   || rsp_last_row !== want.last) begin
                  flag_mismatch($sformatf(
                     "expected row %0d bits %h last %b, got row %0d bits %h last %b",
                     want.row, want.bits, want.last,
                     rsp_row_number, rsp_next_row_bits, rsp_last_row));
               end
            end
         end
      end
   end

   // Row sender: holds a word until it is taken, then waits a random gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (req_valid && !row_taken) begin
         // Word still stalled; keep it on the port.
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (row_queue.size() != 0) begin
         req_valid    <= 1'b1;
         req_row_bits <= row_queue.pop_front();
         gap_left     <= pick_pause();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver: random stalls, plus the long hold-off when it is active.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (hold_active) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= pick_pause();
      end
   end

   initial begin
      wait (hold_arm);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   task automatic queue_row(input logic [lgs_pkg::ROW_W-1:0] bits);
      row_queue.push_back(bits);
      rows_queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (rows_accepted != rows_queued || next_gen_rows.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_side_readback();
      logic [lgs_pkg::CSR_DATA_W-1:0] value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= lgs_pkg::CSR_ADDR_W'(lgs_pkg::REG_BOARD_SIZE) << lgs_pkg::CSR_IDX_LSB;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (value !== lgs_pkg::CSR_DATA_W'(side_setting)) begin
         flag_mismatch($sformatf("board_size read expected %h, got %h",
                                 lgs_pkg::CSR_DATA_W'(side_setting), value));
      end
   endtask

   // Changes the side only once the block has gone quiet.
   task automatic set_side(input logic [lgs_pkg::CSR_DATA_W-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= lgs_pkg::CSR_ADDR_W'(lgs_pkg::REG_BOARD_SIZE) << lgs_pkg::CSR_IDX_LSB;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      side_setting = value[lgs_pkg::SIDE_W-1:0];
      side_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_pwdata  <= {$urandom};
      check_side_readback();
      @(posedge clock);
   endtask

   initial begin
      int                             phase;
      int                             n;
      int                             boards;
      int                             extra;
      int                             r;
      logic [lgs_pkg::CSR_DATA_W-1:0] value;
      logic [lgs_pkg::SIDE_W-1:0]     wild_sides [5];

      wild_sides = '{7'd0, 7'd64, 7'd65, 7'd100, 7'd127};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: tiny boards where wrapped neighbors coincide, a side of
      // zero that acts as one, a half-loaded board cut short, and a plain glider.
      wait_idle();
      check_side_readback();
      set_side(32'd1);
      queue_row('1);
      queue_row('0);
      queue_row(64'h1);
      queue_row(64'h8000_0000_0000_0000);
      set_side(32'd0);
      queue_row(64'h1);
      queue_row(64'hFFFF_FFFF_FFFF_FFFE);
      set_side(32'd2);
      queue_row(64'h3);
      queue_row(64'h1);
      queue_row('1);
      queue_row(64'h2);
      set_side(32'd3);
      queue_row(64'h2);
      queue_row(64'h2);
      queue_row(64'h2);
      queue_row(64'h5);
      queue_row(64'h7);
      // Two rows are loaded; shrinking the side lets the next word finish it.
      set_side(32'hFFFF_FF81);
      queue_row(64'hA);
      set_side(32'd4);
      queue_row(64'h2);
      queue_row(64'h4);
      queue_row(64'h7);
      queue_row(64'h0);

      phase = 0;
      while (rows_queued < TOTAL_ROWS) begin
         r = $urandom_range(0, 99);
         case (phase)
            0: value = 32'd64;
            1: value = 32'd127;
            2: value = 32'd6;
            default: begin
               if (r < 55) begin
                  value = $urandom_range(1, 8);
               end else if (r < 85) begin
                  value = $urandom_range(9, 20);
               end else if (r < 96) begin
                  value = $urandom_range(21, 40);
               end else begin
                  value = lgs_pkg::CSR_DATA_W'(wild_sides[$urandom_range(0, 4)]);
               end
               if ($urandom_range(0, 1) == 1) begin
                  value = value | ({$urandom} & ~lgs_pkg::CSR_DATA_W'(7'h7F));
               end
            end
         endcase
         set_side(value);
         n = effective_side();
         calm = (phase == 2) || ($urandom_range(0, 3) == 0);
         if (n >= 40) begin
            boards = 1;
         end else if (phase == 2) begin
            boards = 6;
            hold_arm = 1'b1;
         end else begin
            boards = $urandom_range(1, 4);
            // Keep the total close to the planned row count.
            while (boards > 1 && rows_queued + boards * n > TOTAL_ROWS) begin
               boards--;
            end
         end
         extra = (n > 1 && n <= 20 && $urandom_range(0, 9) < 4) ? $urandom_range(1, n - 1) : 0;
         repeat (boards * n + extra) queue_row(random_row());
         phase++;
      end

      wait_idle();
      $display("Covered %0d rows in %0d generations over %0d side settings.",
               rows_accepted, generations, side_writes);
      $display("Checked %0d result words, %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0 && next_gen_rows.size() == 0) begin
         $display("life_generation_step_core_test passed");
      end else begin
         $display("life_generation_step_core_test failed");
      end
      $finish;
   end

endmodule
